### hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master bit sequencer: sequencer
// steps, command codes and the result item carried to the output buffer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Sequencer steps; each non-idle step waits, then performs one action
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_START_A  = 4'd1,
        ST_START_B  = 4'd2,
        ST_STOP_A   = 4'd3,
        ST_STOP_B   = 4'd4,
        ST_WR_SETUP = 4'd5,
        ST_WR_RISE  = 4'd6,
        ST_WR_HIGH  = 4'd7,
        ST_WA_SETUP = 4'd8,
        ST_WA_RISE  = 4'd9,
        ST_WA_HIGH  = 4'd10,
        ST_RD_LOW   = 4'd11,
        ST_RD_HIGH  = 4'd12,
        ST_RA_SETUP = 4'd13,
        ST_RA_RISE  = 4'd14,
        ST_RA_HIGH  = 4'd15
    } step_t;

    // Command codes
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd32;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    // One result item
    typedef struct packed {
        logic       scl_released;
        logic       sda_released;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       nack;
    } result_t;

endpackage

### hw/rtl/i2cms_core.sv
// ----------------------------------------------------------------------------
// i2cms_core
// Line sequencer: holds the bus state and, for each accepted item, advances
// the wait counter or performs the next line action in one pass.
// ----------------------------------------------------------------------------
module i2cms_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          phase_ticks,
    input  logic                tick,
    input  logic                cmd_valid,
    input  logic [1:0]          command,
    input  logic [7:0]          tx_byte,
    input  logic                send_ack,
    input  logic                sda_level,
    output i2cms_pkg::result_t  result
);

    i2cms_pkg::step_t step_reg;
    i2cms_pkg::step_t step_next;
    logic [3:0] bit_count_reg;
    logic [3:0] bit_count_next;
    logic [7:0] wait_count_reg;
    logic [7:0] wait_count_next;
    logic [7:0] shift_reg;
    logic [7:0] shift_next;
    logic       scl_hold_reg;
    logic       scl_hold_next;
    logic       sda_hold_reg;
    logic       sda_hold_next;
    logic       ack_choice_reg;
    logic       ack_choice_next;
    logic       nack_reg;
    logic       nack_next;
    logic [7:0] rx_last_reg;
    logic [7:0] rx_last_next;
    logic       done_next;

    logic       half_wait;
    logic [7:0] target;
    logic [8:0] count_sum;
    logic       wait_done;
    logic [3:0] bit_inc;

    // Pick the wait length for the current step and test for its end
    assign half_wait = (step_reg == i2cms_pkg::ST_WR_SETUP) ||
                       (step_reg == i2cms_pkg::ST_WR_RISE)  ||
                       (step_reg == i2cms_pkg::ST_WA_SETUP) ||
                       (step_reg == i2cms_pkg::ST_WA_RISE)  ||
                       (step_reg == i2cms_pkg::ST_RA_SETUP) ||
                       (step_reg == i2cms_pkg::ST_RA_RISE);
    assign target    = half_wait ? {1'b0, phase_ticks[7:1]} : phase_ticks;
    assign count_sum = {1'b0, wait_count_reg} + {8'd0, tick};
    assign wait_done = (count_sum >= {1'b0, target});
    assign bit_inc   = bit_count_reg + 4'd1;

    // Next step
    always_comb
    begin
        step_next = step_reg;
        if (step_reg == i2cms_pkg::ST_IDLE)
        begin
            if (cmd_valid)
            begin
                case (i2cms_pkg::cmd_t'(command))
                    i2cms_pkg::CMD_START: step_next = i2cms_pkg::ST_START_A;
                    i2cms_pkg::CMD_STOP:  step_next = i2cms_pkg::ST_STOP_A;
                    i2cms_pkg::CMD_WRITE: step_next = i2cms_pkg::ST_WR_SETUP;
                    default:              step_next = i2cms_pkg::ST_RD_LOW;
                endcase
            end
        end
        else if (wait_done)
        begin
            case (step_reg)
                i2cms_pkg::ST_START_A:  step_next = i2cms_pkg::ST_START_B;
                i2cms_pkg::ST_START_B:  step_next = i2cms_pkg::ST_IDLE;
                i2cms_pkg::ST_STOP_A:   step_next = i2cms_pkg::ST_STOP_B;
                i2cms_pkg::ST_STOP_B:   step_next = i2cms_pkg::ST_IDLE;
                i2cms_pkg::ST_WR_SETUP: step_next = i2cms_pkg::ST_WR_RISE;
                i2cms_pkg::ST_WR_RISE:  step_next = i2cms_pkg::ST_WR_HIGH;
                i2cms_pkg::ST_WR_HIGH:
                    step_next = (bit_inc >= i2cms_pkg::BITS_PER_BYTE) ?
                                i2cms_pkg::ST_WA_SETUP : i2cms_pkg::ST_WR_SETUP;
                i2cms_pkg::ST_WA_SETUP: step_next = i2cms_pkg::ST_WA_RISE;
                i2cms_pkg::ST_WA_RISE:  step_next = i2cms_pkg::ST_WA_HIGH;
                i2cms_pkg::ST_WA_HIGH:  step_next = i2cms_pkg::ST_IDLE;
                i2cms_pkg::ST_RD_LOW:   step_next = i2cms_pkg::ST_RD_HIGH;
                i2cms_pkg::ST_RD_HIGH:
                    step_next = (bit_inc >= i2cms_pkg::BITS_PER_BYTE) ?
                                i2cms_pkg::ST_RA_SETUP : i2cms_pkg::ST_RD_LOW;
                i2cms_pkg::ST_RA_SETUP: step_next = i2cms_pkg::ST_RA_RISE;
                i2cms_pkg::ST_RA_RISE:  step_next = i2cms_pkg::ST_RA_HIGH;
                i2cms_pkg::ST_RA_HIGH:  step_next = i2cms_pkg::ST_IDLE;
                default:                step_next = i2cms_pkg::ST_IDLE;
            endcase
        end
    end

    // Line actions, counters and data
    always_comb
    begin
        bit_count_next  = bit_count_reg;
        wait_count_next = wait_count_reg;
        shift_next      = shift_reg;
        scl_hold_next   = scl_hold_reg;
        sda_hold_next   = sda_hold_reg;
        ack_choice_next = ack_choice_reg;
        nack_next       = nack_reg;
        rx_last_next    = rx_last_reg;
        done_next       = 1'b0;
        if (step_reg == i2cms_pkg::ST_IDLE)
        begin
            if (cmd_valid)
            begin
                ack_choice_next = send_ack;
                bit_count_next  = 4'd0;
                wait_count_next = 8'd0;
                shift_next      = (i2cms_pkg::cmd_t'(command) == i2cms_pkg::CMD_WRITE) ?
                                  tx_byte : 8'd0;
                case (i2cms_pkg::cmd_t'(command))
                    i2cms_pkg::CMD_START:
                    begin
                        scl_hold_next = 1'b1;
                        sda_hold_next = 1'b1;
                    end
                    i2cms_pkg::CMD_STOP:  sda_hold_next = 1'b0;
                    i2cms_pkg::CMD_WRITE: sda_hold_next = sda_hold_reg;
                    default:              sda_hold_next = 1'b1;
                endcase
            end
        end
        else if (!wait_done)
        begin
            wait_count_next = count_sum[7:0];
        end
        else
        begin
            wait_count_next = 8'd0;
            case (step_reg)
                i2cms_pkg::ST_START_A:  sda_hold_next = 1'b0;
                i2cms_pkg::ST_START_B:
                begin
                    scl_hold_next = 1'b0;
                    done_next     = 1'b1;
                end
                i2cms_pkg::ST_STOP_A:   scl_hold_next = 1'b1;
                i2cms_pkg::ST_STOP_B:
                begin
                    sda_hold_next = 1'b1;
                    done_next     = 1'b1;
                end
                i2cms_pkg::ST_WR_SETUP: sda_hold_next = shift_reg[7];
                i2cms_pkg::ST_WR_RISE:  scl_hold_next = 1'b1;
                i2cms_pkg::ST_WR_HIGH:
                begin
                    scl_hold_next  = 1'b0;
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_count_next = bit_inc;
                end
                i2cms_pkg::ST_WA_SETUP: sda_hold_next = 1'b1;
                i2cms_pkg::ST_WA_RISE:  scl_hold_next = 1'b1;
                i2cms_pkg::ST_WA_HIGH:
                begin
                    nack_next     = sda_level;
                    scl_hold_next = 1'b0;
                    done_next     = 1'b1;
                end
                i2cms_pkg::ST_RD_LOW:   scl_hold_next = 1'b1;
                i2cms_pkg::ST_RD_HIGH:
                begin
                    shift_next     = {shift_reg[6:0], sda_level};
                    scl_hold_next  = 1'b0;
                    bit_count_next = bit_inc;
                end
                i2cms_pkg::ST_RA_SETUP: sda_hold_next = ~ack_choice_reg;
                i2cms_pkg::ST_RA_RISE:  scl_hold_next = 1'b1;
                i2cms_pkg::ST_RA_HIGH:
                begin
                    scl_hold_next = 1'b0;
                    sda_hold_next = 1'b1;
                    rx_last_next  = shift_reg;
                    done_next     = 1'b1;
                end
                default:                done_next = 1'b0;
            endcase
        end
    end

    // Result of this item, taken from the updated state
    always_comb
    begin
        result.scl_released = scl_hold_next;
        result.sda_released = sda_hold_next;
        result.busy         = (step_next != i2cms_pkg::ST_IDLE);
        result.done         = done_next;
        result.rx_byte      = rx_last_next;
        result.nack         = nack_next;
    end

    // Commit state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= i2cms_pkg::ST_IDLE;
            bit_count_reg  <= 4'd0;
            wait_count_reg <= 8'd0;
            shift_reg      <= 8'd0;
            scl_hold_reg   <= 1'b1;
            sda_hold_reg   <= 1'b1;
            ack_choice_reg <= 1'b0;
            nack_reg       <= 1'b0;
            rx_last_reg    <= 8'd0;
        end
        else if (fire)
        begin
            step_reg       <= step_next;
            bit_count_reg  <= bit_count_next;
            wait_count_reg <= wait_count_next;
            shift_reg      <= shift_next;
            scl_hold_reg   <= scl_hold_next;
            sda_hold_reg   <= sda_hold_next;
            ack_choice_reg <= ack_choice_next;
            nack_reg       <= nack_next;
            rx_last_reg    <= rx_last_next;
        end
    end

`ifndef SYNTH
    // A finished command always leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.done |=> step_reg == i2cms_pkg::ST_IDLE)
        else $error("done without return to idle");

    // The bit counter never runs past one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= i2cms_pkg::BITS_PER_BYTE)
        else $error("bit counter overflow");

    // Idle with no command offered stays idle
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && step_reg == i2cms_pkg::ST_IDLE && !cmd_valid
        |=> step_reg == i2cms_pkg::ST_IDLE)
        else $error("left idle without a command");
`endif

endmodule

### hw/rtl/i2cms_out_buf.sv
// ----------------------------------------------------------------------------
// i2cms_out_buf
// Two-entry result buffer: an output register plus a skid register, so an
// item is taken while an earlier result still waits downstream.
// ----------------------------------------------------------------------------
module i2cms_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  i2cms_pkg::result_t  push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output i2cms_pkg::result_t  out_data
);

    logic               main_valid_reg;
    i2cms_pkg::result_t main_data_reg;
    logic               skid_valid_reg;
    i2cms_pkg::result_t skid_data_reg;
    logic               pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= main_valid_reg;
        end
    end

    // Payload: refill from skid first, then from the new item
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

`ifndef SYNTH
    // The skid entry is only used behind a held output entry
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without output entry");

    // A taken result with nothing behind it empties the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !skid_valid_reg && !push |=> !main_valid_reg)
        else $error("result repeated");

    // Nothing is pushed into a full buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("push into full buffer");
`endif

endmodule

### hw/rtl/i2c_master_bit_sequencer.sv
// Each result is registered in the output buffer when its item is accepted.
// Throughput: one item per cycle while in_stall is low; the sequencer step is
// a single pass of next-state logic, and a two-entry output buffer absorbs
// downstream stalls. Input stall rises only when both output entries are full.
// Reset: asynchronous, active low; sequencer idle, both lines released,
// phase_ticks back to 32, output buffer empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that steps SCL/SDA open-drain releases through start, stop,
// write-byte and read-byte programs, one input item per clock while in_stall is low.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       tick,
    input  logic       cmd_valid,
    input  logic [1:0] command,
    input  logic [7:0] tx_byte,
    input  logic       send_ack,
    input  logic       sda_level,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_released,
    output logic       sda_released,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       nack
);

    logic [7:0]         phase_ticks_reg;
    logic               fire;
    logic               buf_full;
    i2cms_pkg::result_t step_result;
    i2cms_pkg::result_t out_data;

    // Hold the phase length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cms_pkg::PHASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    assign in_stall = buf_full;
    assign fire     = in_valid && !buf_full;

    i2cms_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .phase_ticks (phase_ticks_reg),
        .tick        (tick),
        .cmd_valid   (cmd_valid),
        .command     (command),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_level   (sda_level),
        .result      (step_result)
    );

    i2cms_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Drive the result fields
    assign scl_released = out_data.scl_released;
    assign sda_released = out_data.sda_released;
    assign busy_res     = out_data.busy;
    assign done_res     = out_data.done;
    assign rx_byte      = out_data.rx_byte;
    assign nack         = out_data.nack;

endmodule
